@@ src/rlmr_pkg.sv @@
// rlmr_pkg: constants, entry types, state codes and helpers for the
// ranked list merge and rerank block; no dependencies
package rlmr_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int WORK_DEPTH = 2 * LIST_DEPTH;
    localparam int WORK_AW    = $clog2(WORK_DEPTH);
    localparam int WORK_CW    = $clog2(WORK_DEPTH + 1);
    localparam int MAX_WANTED = 64;
    localparam int RES_AW     = $clog2(MAX_WANTED);
    localparam int RES_CW     = 7;

    localparam int ID_W   = 32;
    localparam int RANK_W = 20;
    localparam int SIM_W  = 32;
    localparam int REL_W  = 8;
    localparam int ACT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [RANK_W-1:0]        RANK_MAX = '1;
    localparam logic signed [SIM_W-1:0]  SIM_STEP = 32'sd655;
    localparam logic signed [SIM_W-1:0]  SIM_TOP  = 32'sd6553600;
    localparam logic [RES_CW-1:0]        WANT_CAP = RES_CW'(MAX_WANTED);
    localparam logic [RES_CW-1:0]        WANT_RST = RES_CW'(MAX_WANTED);

    // input actions
    localparam logic [ACT_W-1:0] ACT_LOAD_ONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_TWO = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED    = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE_RD,
        ST_MERGE_CMP,
        ST_SETUP,
        ST_SEL_SCAN,
        ST_SEL_MARK,
        ST_OUT_SCAN,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [RANK_W-1:0]        rank;
        logic signed [SIM_W-1:0]  sim;
        logic [REL_W-1:0]         rel;
    } entry_t;

    typedef struct packed {
        logic                     used;
        logic [ID_W-1:0]          id;
        logic [RANK_W-1:0]        r1;
        logic signed [SIM_W-1:0]  s1;
        logic signed [SIM_W-1:0]  s2;
        logic [REL_W-1:0]         rel;
    } work_t;

    // similarity minus one step, saturating at the most negative value
    function automatic logic signed [SIM_W-1:0] sim_down(input logic signed [SIM_W-1:0] s);
        logic signed [SIM_W:0] d;
        d = {s[SIM_W-1], s} - {SIM_STEP[SIM_W-1], SIM_STEP};
        if (d[SIM_W] != d[SIM_W-1]) begin
            return {1'b1, {(SIM_W-1){1'b0}}};
        end
        return d[SIM_W-1:0];
    endfunction

    // rank plus one, saturating
    function automatic logic [RANK_W-1:0] rank_up(input logic [RANK_W-1:0] r);
        return (r == RANK_MAX) ? r : r + 1'b1;
    endfunction

endpackage

@@ src/ranked_list_merge_rerank.sv @@
// ranked_list_merge_rerank: list stores, merge walk, selection scans and output
// depends on rlmr_pkg
//
// Input channel (s_*): each transaction either appends an entry to list one
// (action 0) or list two (action 1), or starts a run (action 2); action 3 is
// dropped. Loads are taken while idle; entries beyond 1024 per list are dropped.
// A run merges the lists by id in a merge walk, with a read state for the
// synchronous list memory read and a compare state per merged entry, into a
// work memory. Kept and fill entries are then picked one by one: each pick is
// a scan of all merged entries in the work memory at one entry per cycle.
// Results are then emitted in id order, each found by a scan of the result
// memory followed by one output transaction on m_*; m_out_last marks the final
// one. No new transaction is taken until the last result has been accepted.
// A stalled receiver simply holds the output register and the sequencer.
// The user must see that configuration (cfg_*) is written only while idle;
// the block does not enforce it. Reset clears the list counts and control
// state; no memory clearing pass is needed.
module ranked_list_merge_rerank
    import rlmr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ACT_W-1:0]            s_action,
    input  logic [ID_W-1:0]             s_doc_id,
    input  logic [RANK_W-1:0]           s_entry_rank,
    input  logic signed [SIM_W-1:0]     s_entry_sim,
    input  logic [REL_W-1:0]            s_entry_rel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ID_W-1:0]             m_out_doc_id,
    output logic [RANK_W-1:0]           m_out_rank,
    output logic signed [SIM_W-1:0]     m_out_sim,
    output logic [REL_W-1:0]            m_out_rel,
    output logic                        m_out_last
);

    // memories
    entry_t one_mem  [LIST_DEPTH];
    entry_t two_mem  [LIST_DEPTH];
    work_t  work_mem [WORK_DEPTH];
    entry_t res_mem  [MAX_WANTED];

    entry_t one_rd, two_rd, res_rd;
    work_t  work_rd;

    logic                 one_we, two_we, work_we, res_we;
    logic [LIST_AW-1:0]   one_wa, two_wa, one_ra, two_ra;
    logic [WORK_AW-1:0]   work_wa, work_ra;
    logic [RES_AW-1:0]    res_wa, res_ra;
    entry_t               list_wd, res_wd;
    work_t                work_wd;

    // control and datapath registers
    state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_one_reg, cnt_one_next, cnt_two_reg, cnt_two_next;
    logic signed [SIM_W-1:0] thr_reg;
    logic [RES_CW-1:0]   want_reg;
    logic [CNT_W-1:0]    mi_reg, mi_next, mj_reg, mj_next;
    logic [WORK_CW-1:0]  mn_reg, mn_next, k_reg, k_next;
    logic [RANK_W-1:0]   miss_reg, miss_next;
    logic [RES_CW-1:0]   total_reg, total_next, kept_reg, kept_next;
    logic [RES_CW-1:0]   slot_reg, slot_next, emit_reg, emit_next;
    logic [WORK_CW-1:0]  rd_reg, rd_next, pidx_reg, pidx_next, bidx_reg, bidx_next;
    logic                pv_reg, pv_next, bfound_reg, bfound_next;
    work_t               bw_reg, bw_next;
    entry_t              br_reg, br_next;
    logic [RANK_W-1:0]   frank_reg, frank_next;
    logic signed [SIM_W-1:0] fsim_reg, fsim_next;
    logic [MAX_WANTED-1:0] taken_reg, taken_next;
    logic                m_valid_reg, m_valid_next, last_reg, last_next;
    entry_t              out_reg, out_next;

    // combinational helpers
    logic s_acc, have1, have2, take_both, take_one, fill_phase;
    logic cand, better, scan_done;
    logic [WORK_CW-1:0] scan_lim;
    logic [RES_CW-1:0]  want_cap, total_calc;
    work_t              mw;
    logic [RANK_W-1:0]  fill_rank;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign have1     = (mi_reg < cnt_one_reg);
    assign have2     = (mj_reg < cnt_two_reg);
    assign take_both = have1 && have2 && (one_rd.id == two_rd.id);
    assign take_one  = have1 && (!have2 || (one_rd.id < two_rd.id));
    assign fill_phase = (slot_reg >= kept_reg);
    assign want_cap  = (want_reg > WANT_CAP) ? WANT_CAP : want_reg;
    assign total_calc = (mn_reg < WORK_CW'(want_cap)) ? mn_reg[RES_CW-1:0] : want_cap;
    assign fill_rank = rank_up(frank_reg);
    assign scan_lim  = (state_reg == ST_OUT_SCAN) ? WORK_CW'(total_reg) : mn_reg;
    assign scan_done = !pv_reg && (rd_reg >= scan_lim);

    // memory ports
    always_ff @(posedge aclk) begin
        if (one_we) begin
            one_mem[one_wa] <= list_wd;
        end
        one_rd <= one_mem[one_ra];
    end

    always_ff @(posedge aclk) begin
        if (two_we) begin
            two_mem[two_wa] <= list_wd;
        end
        two_rd <= two_mem[two_ra];
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd <= work_mem[work_ra];
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[res_wa] <= res_wd;
        end
        res_rd <= res_mem[res_ra];
    end

    // merged entry built from the two list heads
    always_comb begin
        mw = '0;
        if (take_both) begin
            mw = '{1'b0, one_rd.id, one_rd.rank, one_rd.sim, two_rd.sim, one_rd.rel};
        end else if (take_one) begin
            mw = '{1'b0, one_rd.id, one_rd.rank, one_rd.sim, '0, one_rd.rel};
        end else begin
            mw = '{1'b0, two_rd.id, miss_reg, '0, two_rd.sim, two_rd.rel};
        end
    end

    // candidate test and ordering for the scans
    always_comb begin
        cand   = 1'b0;
        better = 1'b0;
        if (state_reg == ST_OUT_SCAN) begin
            cand   = !taken_reg[pidx_reg[RES_AW-1:0]];
            better = res_rd.id < br_reg.id;
        end else begin
            cand = !work_rd.used &&
                   (fill_phase ? (work_rd.s1 < thr_reg) : (work_rd.s1 >= thr_reg));
            if (fill_phase) begin
                better = (work_rd.s2 > bw_reg.s2) ||
                         ((work_rd.s2 == bw_reg.s2) && (work_rd.s1 > bw_reg.s1));
            end else begin
                better = (work_rd.s1 > bw_reg.s1) ||
                         ((work_rd.s1 == bw_reg.s1) && (work_rd.s2 > bw_reg.s2));
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_action == ACT_RUN)) begin
                    if ((cnt_one_reg == '0) && (cnt_two_reg == '0)) begin
                        state_next = ST_SETUP;
                    end else begin
                        state_next = ST_MERGE_RD;
                    end
                end
            end
            ST_MERGE_RD: begin
                state_next = ST_MERGE_CMP;
            end
            ST_MERGE_CMP: begin
                if ((mi_next < cnt_one_reg) || (mj_next < cnt_two_reg)) begin
                    state_next = ST_MERGE_RD;
                end else begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = (total_calc == '0) ? ST_IDLE : ST_SEL_SCAN;
            end
            ST_SEL_SCAN: begin
                if (scan_done) begin
                    state_next = ST_SEL_MARK;
                end
            end
            ST_SEL_MARK: begin
                state_next = (slot_reg + 1'b1 == total_reg) ? ST_OUT_SCAN : ST_SEL_SCAN;
            end
            ST_OUT_SCAN: begin
                if (scan_done) begin
                    state_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = (emit_reg == total_reg) ? ST_IDLE : ST_OUT_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cnt_one_next = cnt_one_reg;
        cnt_two_next = cnt_two_reg;
        mi_next      = mi_reg;
        mj_next      = mj_reg;
        mn_next      = mn_reg;
        k_next       = k_reg;
        miss_next    = miss_reg;
        total_next   = total_reg;
        kept_next    = kept_reg;
        slot_next    = slot_reg;
        emit_next    = emit_reg;
        rd_next      = rd_reg;
        pidx_next    = pidx_reg;
        pv_next      = pv_reg;
        bidx_next    = bidx_reg;
        bfound_next  = bfound_reg;
        bw_next      = bw_reg;
        br_next      = br_reg;
        frank_next   = frank_reg;
        fsim_next    = fsim_reg;
        taken_next   = taken_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        out_next     = out_reg;

        one_we  = 1'b0;
        two_we  = 1'b0;
        work_we = 1'b0;
        res_we  = 1'b0;
        one_wa  = cnt_one_reg[LIST_AW-1:0];
        two_wa  = cnt_two_reg[LIST_AW-1:0];
        one_ra  = mi_reg[LIST_AW-1:0];
        two_ra  = mj_reg[LIST_AW-1:0];
        list_wd = '{s_doc_id, s_entry_rank, s_entry_sim, s_entry_rel};
        work_wa = mn_reg[WORK_AW-1:0];
        work_wd = mw;
        work_ra = rd_reg[WORK_AW-1:0];
        res_wa  = slot_reg[RES_AW-1:0];
        res_ra  = rd_reg[RES_AW-1:0];
        res_wd  = '{bw_reg.id, bw_reg.r1, bw_reg.s1, bw_reg.rel};

        case (state_reg)
            // list loads and run start
            ST_IDLE: begin
                if (s_acc) begin
                    if ((s_action == ACT_LOAD_ONE) && (cnt_one_reg < CNT_W'(LIST_DEPTH))) begin
                        one_we       = 1'b1;
                        cnt_one_next = cnt_one_reg + 1'b1;
                    end
                    if ((s_action == ACT_LOAD_TWO) && (cnt_two_reg < CNT_W'(LIST_DEPTH))) begin
                        two_we       = 1'b1;
                        cnt_two_next = cnt_two_reg + 1'b1;
                    end
                    if (s_action == ACT_RUN) begin
                        mi_next   = '0;
                        mj_next   = '0;
                        mn_next   = '0;
                        k_next    = '0;
                        miss_next = RANK_W'(cnt_one_reg) + 1'b1;
                    end
                end
            end
            // merge step: write one work entry
            ST_MERGE_CMP: begin
                work_we = 1'b1;
                mn_next = mn_reg + 1'b1;
                if (mw.s1 >= thr_reg) begin
                    k_next = k_reg + 1'b1;
                end
                if (take_both || take_one) begin
                    mi_next = mi_reg + 1'b1;
                end
                if (take_both || !take_one) begin
                    mj_next = mj_reg + 1'b1;
                end
            end
            // result counts and scan start
            ST_SETUP: begin
                cnt_one_next = '0;
                cnt_two_next = '0;
                total_next   = total_calc;
                kept_next    = (k_reg < WORK_CW'(total_calc)) ? k_reg[RES_CW-1:0] : total_calc;
                slot_next    = '0;
                frank_next   = '0;
                fsim_next    = SIM_TOP;
                rd_next      = '0;
                pv_next      = 1'b0;
                bfound_next  = 1'b0;
            end
            // best pick scans, one entry per cycle
            ST_SEL_SCAN, ST_OUT_SCAN: begin
                if (rd_reg < scan_lim) begin
                    rd_next   = rd_reg + 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = rd_reg;
                end else begin
                    pv_next = 1'b0;
                end
                if (pv_reg && cand && (!bfound_reg || better)) begin
                    bfound_next = 1'b1;
                    bidx_next   = pidx_reg;
                    bw_next     = work_rd;
                    br_next     = res_rd;
                end
                if ((state_reg == ST_OUT_SCAN) && scan_done) begin
                    taken_next[bidx_reg[RES_AW-1:0]] = 1'b1;
                    emit_next    = emit_reg + 1'b1;
                    out_next     = br_reg;
                    last_next    = (emit_reg + 1'b1 == total_reg);
                    m_valid_next = 1'b1;
                end
            end
            // mark the pick used and store its result
            ST_SEL_MARK: begin
                work_we      = 1'b1;
                work_wa      = bidx_reg[WORK_AW-1:0];
                work_wd      = bw_reg;
                work_wd.used = 1'b1;
                res_we       = 1'b1;
                if (fill_phase) begin
                    res_wd     = '{bw_reg.id, fill_rank, fsim_reg, bw_reg.rel};
                    frank_next = fill_rank;
                    fsim_next  = sim_down(fsim_reg);
                end else begin
                    frank_next = bw_reg.r1;
                    fsim_next  = sim_down(bw_reg.s1);
                end
                slot_next   = slot_reg + 1'b1;
                rd_next     = '0;
                pv_next     = 1'b0;
                bfound_next = 1'b0;
                if (slot_reg + 1'b1 == total_reg) begin
                    taken_next = '0;
                    emit_next  = '0;
                end
            end
            // hold result until the receiver takes it
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    rd_next      = '0;
                    pv_next      = 1'b0;
                    bfound_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_one_reg <= '0;
            cnt_two_reg <= '0;
            thr_reg     <= '0;
            want_reg    <= WANT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_one_reg <= cnt_one_next;
            cnt_two_reg <= cnt_two_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && (cfg_index == CFG_THRESHOLD)) begin
                thr_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_WANTED)) begin
                want_reg <= cfg_data[RES_CW-1:0];
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge aclk) begin
        mi_reg     <= mi_next;
        mj_reg     <= mj_next;
        mn_reg     <= mn_next;
        k_reg      <= k_next;
        miss_reg   <= miss_next;
        total_reg  <= total_next;
        kept_reg   <= kept_next;
        slot_reg   <= slot_next;
        emit_reg   <= emit_next;
        rd_reg     <= rd_next;
        pidx_reg   <= pidx_next;
        pv_reg     <= pv_next;
        bidx_reg   <= bidx_next;
        bfound_reg <= bfound_next;
        bw_reg     <= bw_next;
        br_reg     <= br_next;
        frank_reg  <= frank_next;
        fsim_reg   <= fsim_next;
        taken_reg  <= taken_next;
        last_reg   <= last_next;
        out_reg    <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_doc_id = out_reg.id;
    assign m_out_rank   = out_reg.rank;
    assign m_out_sim    = out_reg.sim;
    assign m_out_rel    = out_reg.rel;
    assign m_out_last   = last_reg;

    // checks
    a_valid_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_OUT_WAIT))
        else $error("result valid outside output wait");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_one_reg <= CNT_W'(LIST_DEPTH)) && (cnt_two_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_mark_has_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL_MARK) |-> (bfound_reg && (slot_reg < total_reg)))
        else $error("pick stored without a candidate");

    a_emit_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT_WAIT) |-> ((emit_reg <= total_reg) && (emit_reg != '0)))
        else $error("emitted count out of range");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && last_reg) |=> (state_reg == ST_IDLE))
        else $error("run not finished after last result");

endmodule

@@ bench/rlmr_checker.sv @@
`timescale 1ns / 100ps
// rlmr_checker: watches the load, result and register ports of the merge and
// rerank block, predicts each result list and compares; depends on rlmr_pkg
module rlmr_checker
    import rlmr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [ACT_W-1:0]        s_action,
    input  logic [ID_W-1:0]         s_doc_id,
    input  logic [RANK_W-1:0]       s_entry_rank,
    input  logic signed [SIM_W-1:0] s_entry_sim,
    input  logic [REL_W-1:0]        s_entry_rel,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [ID_W-1:0]         m_out_doc_id,
    input  logic [RANK_W-1:0]       m_out_rank,
    input  logic signed [SIM_W-1:0] m_out_sim,
    input  logic [REL_W-1:0]        m_out_rel,
    input  logic                    m_out_last,
    output int                      error_count,
    output int                      pending
);

    typedef struct {
        logic [ID_W-1:0]         id;
        logic [RANK_W-1:0]       r1;
        logic signed [SIM_W-1:0] s1;
        logic signed [SIM_W-1:0] s2;
        logic [REL_W-1:0]        rel;
    } joined_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [RANK_W-1:0]       rank;
        logic signed [SIM_W-1:0] sim;
        logic [REL_W-1:0]        rel;
        logic                    last;
    } scored_t;

    entry_t                  first_list[LIST_DEPTH];
    entry_t                  second_list[LIST_DEPTH];
    int                      first_count;
    int                      second_count;
    logic signed [SIM_W-1:0] keep_floor;
    logic [6:0]              wanted;
    scored_t                 scored_q[$];
    int                      errs = 0;

    function automatic logic [RANK_W-1:0] next_rank(input logic [RANK_W-1:0] r);
        return (r == '1) ? r : r + 1'b1;
    endfunction

    // true when a must stand ahead of b in the chosen similarity order
    function automatic bit ahead(input joined_t a, input joined_t b, input bit by_second);
        if (by_second) begin
            if (a.s2 != b.s2) return a.s2 > b.s2;
            return a.s1 > b.s1;
        end
        if (a.s1 != b.s1) return a.s1 > b.s1;
        return a.s2 > b.s2;
    endfunction

    // stable insertion sort of q[lo..hi)
    function automatic void order_joined(ref joined_t q[$], input int lo, input int hi,
                                         input bit by_second);
        joined_t t;
        int      j;
        for (int i = lo + 1; i < hi; i++) begin
            t = q[i];
            j = i;
            while (j > lo && ahead(t, q[j-1], by_second)) begin
                q[j] = q[j-1];
                j--;
            end
            q[j] = t;
        end
    endfunction

    // merge both lists, pick kept and fill entries, queue them in id order
    function automatic void rerank_lists();
        joined_t          pool[$];
        joined_t          jn;
        scored_t          picks[$];
        scored_t          sc;
        int               i, j, k, m, total, kept, cap;
        logic [RANK_W-1:0] miss_rank, cur_rank;
        longint           cur_sim;
        miss_rank = RANK_W'(first_count + 1);
        i = 0;
        j = 0;
        while (i < first_count || j < second_count) begin
            if (i < first_count && j < second_count
                    && first_list[i].id == second_list[j].id) begin
                jn = '{first_list[i].id, first_list[i].rank, first_list[i].sim,
                       second_list[j].sim, first_list[i].rel};
                i++;
                j++;
            end else if (i < first_count
                    && (j >= second_count || first_list[i].id < second_list[j].id)) begin
                jn = '{first_list[i].id, first_list[i].rank, first_list[i].sim,
                       32'sd0, first_list[i].rel};
                i++;
            end else begin
                jn = '{second_list[j].id, miss_rank, 32'sd0, second_list[j].sim,
                       second_list[j].rel};
                j++;
            end
            pool.push_back(jn);
        end
        m = pool.size();
        cap = (wanted > MAX_WANTED) ? MAX_WANTED : int'(wanted);
        total = (cap < m) ? cap : m;
        order_joined(pool, 0, m, 1'b0);
        k = 0;
        while (k < m && pool[k].s1 >= keep_floor) k++;
        kept = (k < total) ? k : total;
        for (i = 0; i < kept; i++) begin
            picks.push_back('{pool[i].id, pool[i].r1, pool[i].s1, pool[i].rel, 1'b0});
        end
        if (kept > 0) begin
            cur_rank = picks[kept-1].rank;
            cur_sim = longint'(picks[kept-1].sim) - 655;
        end else begin
            cur_rank = '0;
            cur_sim = 6553600;
        end
        if (cur_sim < -64'sd2147483648) cur_sim = -64'sd2147483648;
        if (kept < total) begin
            order_joined(pool, k, m, 1'b1);
            for (i = kept; i < total; i++) begin
                cur_rank = next_rank(cur_rank);
                picks.push_back('{pool[i].id, cur_rank, SIM_W'(cur_sim), pool[i].rel, 1'b0});
                cur_sim -= 655;
                if (cur_sim < -64'sd2147483648) cur_sim = -64'sd2147483648;
            end
        end
        // stable id order for emission
        for (i = 1; i < total; i++) begin
            sc = picks[i];
            j = i;
            while (j > 0 && sc.id < picks[j-1].id) begin
                picks[j] = picks[j-1];
                j--;
            end
            picks[j] = sc;
        end
        for (i = 0; i < total; i++) begin
            sc = picks[i];
            sc.last = (i + 1 == total);
            scored_q.push_back(sc);
        end
    endfunction

    // follow registers, loads, runs and emitted results
    always @(posedge aclk) begin
        scored_t want_r;
        if (!aresetn) begin
            first_count = 0;
            second_count = 0;
            keep_floor = '0;
            wanted = 7'd64;
            scored_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_THRESHOLD) keep_floor = cfg_data;
                else if (cfg_index == CFG_WANTED) wanted = cfg_data[6:0];
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_LOAD_ONE && first_count < LIST_DEPTH) begin
                    first_list[first_count] = '{s_doc_id, s_entry_rank, s_entry_sim,
                                                s_entry_rel};
                    first_count++;
                end else if (s_action == ACT_LOAD_TWO && second_count < LIST_DEPTH) begin
                    second_list[second_count] = '{s_doc_id, s_entry_rank, s_entry_sim,
                                                  s_entry_rel};
                    second_count++;
                end else if (s_action == ACT_RUN) begin
                    rerank_lists();
                    first_count = 0;
                    second_count = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (scored_q.size() == 0) begin
                    $display("%0t: unexpected result id=%h rank=%h sim=%h rel=%h last=%b",
                             $time, m_out_doc_id, m_out_rank, m_out_sim, m_out_rel,
                             m_out_last);
                    errs++;
                end else begin
                    want_r = scored_q.pop_front();
                    if (m_out_doc_id !== want_r.id) begin
                        $display("%0t: doc_id expected %h actual %h", $time, want_r.id,
                                 m_out_doc_id);
                        errs++;
                    end
                    if (m_out_rank !== want_r.rank) begin
                        $display("%0t: rank expected %h actual %h", $time, want_r.rank,
                                 m_out_rank);
                        errs++;
                    end
                    if (m_out_sim !== want_r.sim) begin
                        $display("%0t: sim expected %h actual %h", $time, want_r.sim,
                                 m_out_sim);
                        errs++;
                    end
                    if (m_out_rel !== want_r.rel) begin
                        $display("%0t: rel expected %h actual %h", $time, want_r.rel,
                                 m_out_rel);
                        errs++;
                    end
                    if (m_out_last !== want_r.last) begin
                        $display("%0t: last expected %b actual %b", $time, want_r.last,
                                 m_out_last);
                        errs++;
                    end
                end
            end
        end
        pending <= scored_q.size();
        error_count <= errs;
    end

endmodule

@@ bench/tb_ranked_list_merge_rerank.sv @@
`timescale 1ns / 100ps
// tb_ranked_list_merge_rerank: stimulus, receiver stalls and verdict for the
// merge and rerank block; depends on rlmr_pkg and rlmr_checker
module tb_ranked_list_merge_rerank;
    import rlmr_pkg::*;

    localparam int IDLE_LIMIT = 50000;
    localparam int SIM_LO = -2147483647 - 1;
    localparam int SIM_HI = 2147483647;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [ACT_W-1:0]        s_action = '0;
    logic [ID_W-1:0]         s_doc_id = '0;
    logic [RANK_W-1:0]       s_entry_rank = '0;
    logic signed [SIM_W-1:0] s_entry_sim = '0;
    logic [REL_W-1:0]        s_entry_rel = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [ID_W-1:0]         m_out_doc_id;
    logic [RANK_W-1:0]       m_out_rank;
    logic signed [SIM_W-1:0] m_out_sim;
    logic [REL_W-1:0]        m_out_rel;
    logic                    m_out_last;
    int                      error_count;
    int                      pending;

    int burst_left = 0;
    bit gaps_on = 1'b1;
    int loads_sent = 0;
    int quiet_cycles = 0;

    ranked_list_merge_rerank dut (.*);

    rlmr_checker u_checker (.*);

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern: switches among four modes, picked at random
    always @(posedge aclk) begin
        int stall_mode;
        int cyc;
        cyc++;
        if (cyc % 200 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (cyc % 7) < 2;
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transaction, with bursts and random gaps ahead of it
    task automatic push_txn(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                            input logic [RANK_W-1:0] rank, input logic [SIM_W-1:0] sim,
                            input logic [REL_W-1:0] rel);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_action <= act;
        s_doc_id <= id;
        s_entry_rank <= rank;
        s_entry_sim <= sim;
        s_entry_rel <= rel;
        do @(posedge aclk); while (!s_ready);
        if (act == ACT_LOAD_ONE || act == ACT_LOAD_TWO) loads_sent++;
    endtask

    // wait until every result is in and the block is idle again
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // both registers, written while idle
    task automatic set_regs(input logic [31:0] floor_v, input logic [6:0] want_v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= floor_v;
        @(posedge aclk);
        cfg_index <= CFG_WANTED;
        cfg_data <= {25'd0, want_v};
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // one query with random content; centre sets the similarity band
    task automatic random_query(input int pool_n, input logic signed [31:0] centre);
        entry_t       l1[$];
        entry_t       l2[$];
        entry_t       e;
        logic [31:0]  base;
        int           pick, span;
        longint       s;
        bit           wide;
        wide = ($urandom_range(0, 3) == 0);
        base = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
        span = $urandom_range(1, 3);
        for (int c = 0; c < pool_n; c++) begin
            e.id = base + c * span;
            if ($urandom_range(0, 15) == 0) e.id = base;
            e.rank = ($urandom_range(0, 7) == 0) ? $urandom_range(20'hFFF00, 20'hFFFFF)
                                                 : $urandom_range(0, 200);
            s = wide ? longint'($signed($urandom))
                     : longint'(centre) + $urandom_range(0, 2000) - 1000;
            if (s > SIM_HI) s = SIM_HI;
            if (s < SIM_LO) s = SIM_LO;
            e.sim = 32'(s);
            e.rel = $urandom_range(0, 255);
            pick = $urandom_range(0, 3);
            if (pick != 1) l1.push_back(e);
            if (pick != 0) begin
                s = wide ? longint'($signed($urandom))
                         : longint'(centre) + $urandom_range(0, 2000) - 1000;
                if (s > SIM_HI) s = SIM_HI;
                if (s < SIM_LO) s = SIM_LO;
                e.sim = 32'(s);
                e.rel = $urandom_range(0, 255);
                e.rank = $urandom_range(0, 20'hFFFFF);
                l2.push_back(e);
            end
        end
        // a few broken queries with lists out of order
        if ($urandom_range(0, 19) == 0) l1.shuffle();
        if ($urandom_range(0, 19) == 0) l2.shuffle();
        while (l1.size() + l2.size() > 0) begin
            if ($urandom_range(0, 29) == 0)
                push_txn(2'd3, $urandom, $urandom, $urandom, $urandom);
            if (l2.size() == 0 || (l1.size() != 0 && $urandom_range(0, 1) == 0)) begin
                e = l1.pop_front();
                push_txn(ACT_LOAD_ONE, e.id, e.rank, e.sim, e.rel);
            end else begin
                e = l2.pop_front();
                push_txn(ACT_LOAD_TWO, e.id, e.rank, e.sim, e.rel);
            end
        end
        push_txn(ACT_RUN, $urandom, $urandom, $urandom, $urandom);
    endtask

    // stimulus and verdict
    initial begin
        logic signed [31:0] floor_r;
        int                 q_n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, missing documents on both sides, unused action
        push_txn(ACT_LOAD_ONE, 32'd0, 20'd0, 32'h7FFFFFFF, 8'hFF);
        push_txn(ACT_LOAD_TWO, 32'd5, 20'd3, 32'hFFFFFFFF, 8'hAA);
        push_txn(2'd3, 32'hFFFFFFFF, 20'hFFFFF, 32'h80000000, 8'hFF);
        push_txn(ACT_LOAD_ONE, 32'd5, 20'hFFFFF, 32'd0, 8'h00);
        push_txn(ACT_LOAD_TWO, 32'hFFFFFFFF, 20'd7, 32'h80000000, 8'h01);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);
        // empty lists give no result
        push_txn(ACT_RUN, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 8'hFF);

        // rank and similarity saturation on the fill
        set_regs(32'h80000064, 7'd64);
        push_txn(ACT_LOAD_ONE, 32'd10, 20'hFFFFF, 32'h80000064, 8'd3);
        push_txn(ACT_LOAD_ONE, 32'd11, 20'd1, 32'h80000000, 8'd4);
        push_txn(ACT_LOAD_ONE, 32'd12, 20'd2, 32'h80000000, 8'd5);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);

        // nothing kept: fill starts from the top similarity
        set_regs(32'h7FFFFFFF, 7'd1);
        push_txn(ACT_LOAD_ONE, 32'd20, 20'd1, 32'd100, 8'd1);
        push_txn(ACT_LOAD_TWO, 32'd21, 20'd2, 32'd200, 8'd2);
        push_txn(ACT_LOAD_TWO, 32'd20, 20'd3, 32'd300, 8'd3);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);

        // more kept than wanted, with duplicate ids
        set_regs(32'h80000000, 7'd2);
        push_txn(ACT_LOAD_ONE, 32'd30, 20'd1, 32'd9, 8'd1);
        push_txn(ACT_LOAD_ONE, 32'd30, 20'd2, 32'd9, 8'd2);
        push_txn(ACT_LOAD_ONE, 32'd31, 20'd3, 32'd7, 8'd3);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);

        // wanted zero gives no result
        set_regs(32'd0, 7'd0);
        push_txn(ACT_LOAD_ONE, 32'd40, 20'd1, 32'd1, 8'd1);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);

        // more merged entries than the cap, wanted above the cap
        set_regs(32'd65536, 7'd127);
        gaps_on = 1'b0;
        for (int n = 0; n < 70; n++)
            push_txn(ACT_LOAD_ONE, 32'(n * 3), 20'(n), $urandom, $urandom);
        push_txn(ACT_LOAD_TWO, 32'd4, 20'd1, 32'd70000, 8'd9);
        push_txn(ACT_LOAD_TWO, 32'd3000, 20'd2, 32'd5, 8'd8);
        push_txn(ACT_RUN, 32'd0, 20'd0, 32'd0, 8'd0);
        gaps_on = 1'b1;
        drain();

        // random queries over several register settings
        q_n = 0;
        while (loads_sent < 220) begin
            if (q_n % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0: floor_r = 32'sh80000000;
                    1: floor_r = 32'sh7FFFFFFF;
                    2: floor_r = $urandom;
                    default: floor_r = $urandom_range(0, 20000) - 10000;
                endcase
                set_regs(floor_r, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 12));
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            random_query(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(0, 10),
                         floor_r);
            q_n++;
        end

        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
